/* hw/rtl/rmsdb_pkg.sv */
package rmsdb_pkg;

  localparam int unsigned WINDOW_FRAMES = 512;
  localparam int unsigned LOG_STEPS     = 20000;

  localparam int unsigned WIN_W  = $clog2(WINDOW_FRAMES + 1);
  localparam int unsigned IDX_W  = $clog2(LOG_STEPS + 1);
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CAP_W  = 43;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned LOG_W  = 28;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned EXP_W  = LOG_W - FRAC_W;

  // int16 scale 4e-9 folded with the step count: idx = S / (n * INT_SCALE)
  localparam int unsigned INT_SCALE = 1000000000 / (4 * LOG_STEPS);
  localparam int unsigned SCL_W     = $clog2(INT_SCALE + 1);
  localparam int unsigned DSR_W     = $clog2(WINDOW_FRAMES * INT_SCALE + 1);
  localparam int unsigned DSH_W     = DSR_W + IDX_W - 1;

  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
  localparam logic [CAP_W-1:0]  SUM_CAP    = {1'b1, {(CAP_W-1){1'b0}}};
  localparam logic [IDX_W-1:0]  IDX_MAX    = IDX_W'(LOG_STEPS);
  localparam logic [31:0]       MUL_STEPS  = 32'(LOG_STEPS);
  localparam logic [31:0]       LOG_K      = 32'd50504453;
  localparam logic [63:0]       RND_HALF   = 64'h0000_0080_0000_0000;
  localparam logic [15:0]       DB_MAG_MAX = 16'd25600;
  localparam logic signed [15:0] DB_FLOOR  = -16'sd25600;

  localparam logic REG_FORMAT   = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic [15:0] frames_in_buffer;
    logic        last_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] left_level_db;
    logic signed [15:0] right_level_db;
  } out_beat_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQR,
    OP_ACC,
    OP_INIT,
    OP_MLO,
    OP_MHI,
    OP_FN,
    OP_DCHK,
    OP_DSTEP,
    OP_LINIT,
    OP_LSQR,
    OP_LUPD,
    OP_DSUB,
    OP_DMUL,
    OP_DFIN,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   ch;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic stereo;
    logic is_float;
    logic out_free;
  } dp_stat_t;

  // log2 in Q.24 by repeated squaring; elaboration only
  function automatic logic [LOG_W-1:0] log2_q24(input logic [IDX_W-1:0] x);
    logic [EXP_W-1:0] n;
    logic [63:0]      y;
    logic [LOG_W-1:0] r;
    n = '0;
    for (int k = 1; k < IDX_W; k++) begin
      if (x[k]) begin
        n = EXP_W'(k);
      end
    end
    y = 64'(x) << (31 - n);
    r = {n, {FRAC_W{1'b0}}};
    for (int i = FRAC_W - 1; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y[32]) begin
        y = y >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [LOG_W-1:0] LOG_REF = log2_q24(IDX_MAX);

endpackage

/* hw/rtl/rmsdb_ctrl.sv */
module rmsdb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmsdb_pkg::dp_stat_t stat_i,
  output rmsdb_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQR   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_MLO   = 4'd4;
  localparam logic [3:0] S_MHI   = 4'd5;
  localparam logic [3:0] S_FN    = 4'd6;
  localparam logic [3:0] S_DCHK  = 4'd7;
  localparam logic [3:0] S_DSTEP = 4'd8;
  localparam logic [3:0] S_LINIT = 4'd9;
  localparam logic [3:0] S_LSQR  = 4'd10;
  localparam logic [3:0] S_LUPD  = 4'd11;
  localparam logic [3:0] S_DSUB  = 4'd12;
  localparam logic [3:0] S_DMUL  = 4'd13;
  localparam logic [3:0] S_DFIN  = 4'd14;
  localparam logic [3:0] S_EMIT  = 4'd15;

  localparam logic [4:0] DIV_LAST = 5'(rmsdb_pkg::IDX_W - 1);
  localparam logic [4:0] LOG_LAST = 5'(rmsdb_pkg::FRAC_W - 1);

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       ch_q, ch_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ch_d      = ch_q;
    cmd_o.op  = rmsdb_pkg::OP_NOP;
    cmd_o.ch  = ch_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rmsdb_pkg::OP_LOAD;
          state_d  = S_SQR;
        end
      end
      S_SQR: begin
        cmd_o.op = rmsdb_pkg::OP_SQR;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = rmsdb_pkg::OP_ACC;
        ch_d     = 1'b0;
        state_d  = stat_i.last ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        cmd_o.op = rmsdb_pkg::OP_INIT;
        state_d  = stat_i.is_float ? S_MLO : S_DCHK;
      end
      S_MLO: begin
        cmd_o.op = rmsdb_pkg::OP_MLO;
        state_d  = S_MHI;
      end
      S_MHI: begin
        cmd_o.op = rmsdb_pkg::OP_MHI;
        state_d  = S_FN;
      end
      S_FN: begin
        cmd_o.op = rmsdb_pkg::OP_FN;
        state_d  = S_DCHK;
      end
      S_DCHK: begin
        cmd_o.op = rmsdb_pkg::OP_DCHK;
        cnt_d    = DIV_LAST;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = rmsdb_pkg::OP_DSTEP;
        if (cnt_q == '0) begin
          state_d = S_LINIT;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_LINIT: begin
        cmd_o.op = rmsdb_pkg::OP_LINIT;
        cnt_d    = LOG_LAST;
        state_d  = S_LSQR;
      end
      S_LSQR: begin
        cmd_o.op = rmsdb_pkg::OP_LSQR;
        state_d  = S_LUPD;
      end
      S_LUPD: begin
        cmd_o.op = rmsdb_pkg::OP_LUPD;
        if (cnt_q == '0) begin
          state_d = S_DSUB;
        end else begin
          cnt_d   = cnt_q - 5'd1;
          state_d = S_LSQR;
        end
      end
      S_DSUB: begin
        cmd_o.op = rmsdb_pkg::OP_DSUB;
        state_d  = S_DMUL;
      end
      S_DMUL: begin
        cmd_o.op = rmsdb_pkg::OP_DMUL;
        state_d  = S_DFIN;
      end
      S_DFIN: begin
        cmd_o.op = rmsdb_pkg::OP_DFIN;
        if (!ch_q && stat_i.stereo) begin
          ch_d    = 1'b1;
          state_d = S_INIT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = rmsdb_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ch_q    <= ch_d;
    end
  end

  a_last_starts_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && stat_i.last) |=> (state_q == S_INIT && !ch_q))
    else $error("final beat did not start the left channel");

  a_right_only_stereo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT && ch_q) |-> stat_i.stereo)
    else $error("right channel worked on in mono");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DSTEP) |-> (cnt_q <= DIV_LAST))
    else $error("divider step count out of range");

endmodule

/* hw/rtl/rmsdb_dp.sv */
module rmsdb_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fmt_i,
  input  logic [1:0]           chn_i,
  input  rmsdb_pkg::in_beat_t  in_data_i,
  input  rmsdb_pkg::dp_cmd_t   cmd_i,
  output rmsdb_pkg::dp_stat_t  stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rmsdb_pkg::out_beat_t out_data_o
);

  localparam int unsigned WIN_W = rmsdb_pkg::WIN_W;
  localparam int unsigned IDX_W = rmsdb_pkg::IDX_W;
  localparam int unsigned SUM_W = rmsdb_pkg::SUM_W;
  localparam int unsigned CAP_W = rmsdb_pkg::CAP_W;
  localparam int unsigned MAG_W = rmsdb_pkg::MAG_W;
  localparam int unsigned DSR_W = rmsdb_pkg::DSR_W;
  localparam int unsigned DSH_W = rmsdb_pkg::DSH_W;
  localparam int unsigned EXP_W = rmsdb_pkg::EXP_W;
  localparam int unsigned FRAC_W = rmsdb_pkg::FRAC_W;
  localparam int unsigned LOG_W = rmsdb_pkg::LOG_W;

  // control state
  logic [1:0][SUM_W-1:0] sum_q, sum_d;
  logic                  tog_q, tog_d;
  logic [15:0]           fidx_q, fidx_d;
  logic                  last_q, last_d;
  logic                  stereo_q, stereo_d;
  logic                  out_valid_q, out_valid_d;

  // payload
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic                  ch_q, ch_d;
  logic                  win_q, win_d;
  logic [WIN_W-1:0]      n_q, n_d;
  logic [63:0]           prod_q, prod_d;
  logic [CAP_W-1:0]      num_q, num_d;
  logic [DSR_W-1:0]      dsr_q, dsr_d;
  logic [DSH_W-1:0]      dsh_q, dsh_d;
  logic [IDX_W-1:0]      quot_q, quot_d;
  logic                  ovf_q, ovf_d;
  logic                  zero_q, zero_d;
  logic [31:0]           y_q, y_d;
  logic [EXP_W-1:0]      lexp_q, lexp_d;
  logic [FRAC_W-1:0]     frac_q, frac_d;
  logic [1:0][15:0]      res_q, res_d;
  rmsdb_pkg::out_beat_t  out_q, out_d;

  // sample magnitude
  logic [31:0]       bits;
  logic [7:0]        fexp;
  logic [7:0]        fsh;
  logic [23:0]       fshf;
  logic [MAG_W-1:0]  mag_in;
  logic [MAG_W-1:0]  mag_sat;

  always_comb begin
    bits    = in_data_i.sample_bits;
    fexp    = bits[30:23];
    fsh     = 8'd135 - fexp;
    fshf    = (fsh > 8'd31) ? '0 : ({1'b1, bits[22:0]} >> fsh[4:0]);
    mag_sat = bits[31] ? 16'h8000 : 16'h7fff;
    if (!fmt_i) begin
      mag_in = bits[15] ? (~bits[15:0] + 16'd1) : bits[15:0];
    end else if (fexp == 8'hff) begin
      mag_in = (bits[22:0] != '0) ? '0 : mag_sat;
    end else if (fexp == 8'h00) begin
      mag_in = '0;
    end else if (fexp >= 8'd127) begin
      mag_in = mag_sat;
    end else begin
      mag_in = fshf[MAG_W-1:0];
    end
  end

  // window and channel bookkeeping for the incoming beat
  logic [15:0]      frames;
  logic [15:0]      win_start;
  logic [WIN_W-1:0] n_in;
  logic             stereo_in;
  logic             ch_in;

  always_comb begin
    frames    = in_data_i.frames_in_buffer;
    win_start = (frames > 16'(rmsdb_pkg::WINDOW_FRAMES)) ?
                (frames - 16'(rmsdb_pkg::WINDOW_FRAMES)) : '0;
    n_in      = (frames < 16'(rmsdb_pkg::WINDOW_FRAMES)) ?
                frames[WIN_W-1:0] : WIN_W'(rmsdb_pkg::WINDOW_FRAMES);
    if (n_in == '0) begin
      n_in = WIN_W'(1);
    end
    stereo_in = chn_i[1];
    ch_in     = stereo_in & tog_q;
  end

  // shared 32x32 multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd_i.op)
      rmsdb_pkg::OP_SQR: begin
        mul_a = 32'(mag_q);
        mul_b = 32'(mag_q);
      end
      rmsdb_pkg::OP_MLO: begin
        mul_a = num_q[31:0];
        mul_b = rmsdb_pkg::MUL_STEPS;
      end
      rmsdb_pkg::OP_MHI: begin
        mul_a = 32'(num_q[CAP_W-1:32]);
        mul_b = rmsdb_pkg::MUL_STEPS;
      end
      rmsdb_pkg::OP_LSQR: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      rmsdb_pkg::OP_DMUL: begin
        mul_a = y_q;
        mul_b = rmsdb_pkg::LOG_K;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // per-op helpers
  logic             rd_ch;
  logic [SUM_W-1:0] sum_rd;
  logic [SUM_W:0]   acc_sum;
  logic [CAP_W-1:0] s_cap;
  logic [IDX_W-1:0] idx;
  logic [EXP_W-1:0] lz;
  logic [32:0]      sq_t;
  logic [LOG_W-1:0] lg_a;
  logic [63:0]      rnd;
  logic [23:0]      p_raw;
  logic [15:0]      p_mag;

  always_comb begin
    rd_ch   = (cmd_i.op == rmsdb_pkg::OP_ACC) ? ch_q : cmd_i.ch;
    sum_rd  = sum_q[rd_ch];
    acc_sum = {1'b0, sum_rd} + (SUM_W+1)'(prod_q[31:0]);
    s_cap   = (sum_rd > SUM_W'(rmsdb_pkg::SUM_CAP)) ? rmsdb_pkg::SUM_CAP :
              sum_rd[CAP_W-1:0];
    idx     = (ovf_q || quot_q > rmsdb_pkg::IDX_MAX) ? rmsdb_pkg::IDX_MAX : quot_q;
    lz      = '0;
    for (int k = 1; k < IDX_W; k++) begin
      if (idx[k]) begin
        lz = EXP_W'(k);
      end
    end
    sq_t    = prod_q[63:31];
    lg_a    = {lexp_q, frac_q};
    rnd     = prod_q + rmsdb_pkg::RND_HALF;
    p_raw   = rnd[63:40];
    p_mag   = (p_raw > 24'(rmsdb_pkg::DB_MAG_MAX)) ? rmsdb_pkg::DB_MAG_MAX : p_raw[15:0];
  end

  always_comb begin
    sum_d       = sum_q;
    tog_d       = tog_q;
    fidx_d      = fidx_q;
    last_d      = last_q;
    stereo_d    = stereo_q;
    out_valid_d = out_valid_q && out_stall_i;
    mag_d       = mag_q;
    ch_d        = ch_q;
    win_d       = win_q;
    n_d         = n_q;
    prod_d      = mul_en ? (64'(mul_a) * 64'(mul_b)) : prod_q;
    num_d       = num_q;
    dsr_d       = dsr_q;
    dsh_d       = dsh_q;
    quot_d      = quot_q;
    ovf_d       = ovf_q;
    zero_d      = zero_q;
    y_d         = y_q;
    lexp_d      = lexp_q;
    frac_d      = frac_q;
    res_d       = res_q;
    out_d       = out_q;
    unique case (cmd_i.op)
      rmsdb_pkg::OP_LOAD: begin
        mag_d    = mag_in;
        ch_d     = ch_in;
        win_d    = (fidx_q >= win_start);
        n_d      = n_in;
        last_d   = in_data_i.last_sample;
        stereo_d = stereo_in;
        if (stereo_in && !ch_in) begin
          tog_d = 1'b1;
        end else begin
          tog_d  = 1'b0;
          fidx_d = fidx_q + 16'd1;
        end
      end
      rmsdb_pkg::OP_ACC: begin
        if (win_q) begin
          sum_d[ch_q] = acc_sum[SUM_W] ? rmsdb_pkg::SUM_MAX : acc_sum[SUM_W-1:0];
        end
      end
      rmsdb_pkg::OP_INIT: begin
        num_d = s_cap;
        dsr_d = fmt_i ? DSR_W'(n_q) :
                (DSR_W'(n_q) * DSR_W'(rmsdb_pkg::INT_SCALE));
      end
      rmsdb_pkg::OP_MHI: begin
        num_d = CAP_W'(prod_q[46:30]);
      end
      rmsdb_pkg::OP_FN: begin
        num_d = CAP_W'({prod_q[25:0], 2'b00}) + num_q;
      end
      rmsdb_pkg::OP_DCHK: begin
        dsh_d  = {dsr_q, {(IDX_W-1){1'b0}}};
        ovf_d  = (num_q >= CAP_W'({dsr_q, {IDX_W{1'b0}}}));
        quot_d = '0;
      end
      rmsdb_pkg::OP_DSTEP: begin
        if (num_q >= CAP_W'(dsh_q)) begin
          num_d  = num_q - CAP_W'(dsh_q);
          quot_d = {quot_q[IDX_W-2:0], 1'b1};
        end else begin
          quot_d = {quot_q[IDX_W-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
      end
      rmsdb_pkg::OP_LINIT: begin
        zero_d = (idx == '0);
        y_d    = 32'(idx) << (5'd31 - 5'(lz));
        lexp_d = lz;
        frac_d = '0;
      end
      rmsdb_pkg::OP_LUPD: begin
        y_d    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        frac_d = {frac_q[FRAC_W-2:0], sq_t[32]};
      end
      rmsdb_pkg::OP_DSUB: begin
        y_d = (rmsdb_pkg::LOG_REF > lg_a) ? 32'(rmsdb_pkg::LOG_REF - lg_a) : '0;
      end
      rmsdb_pkg::OP_DFIN: begin
        res_d[cmd_i.ch] = zero_q ? rmsdb_pkg::DB_FLOOR : (~p_mag + 16'd1);
      end
      rmsdb_pkg::OP_EMIT: begin
        out_d.left_level_db  = res_q[0];
        out_d.right_level_db = stereo_q ? res_q[1] : rmsdb_pkg::DB_FLOOR;
        out_valid_d          = 1'b1;
        sum_d                = '0;
        tog_d                = 1'b0;
        fidx_d               = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      tog_q       <= 1'b0;
      fidx_q      <= '0;
      last_q      <= 1'b0;
      stereo_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      tog_q       <= tog_d;
      fidx_q      <= fidx_d;
      last_q      <= last_d;
      stereo_q    <= stereo_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    ch_q   <= ch_d;
    win_q  <= win_d;
    n_q    <= n_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    dsr_q  <= dsr_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
    zero_q <= zero_d;
    y_q    <= y_d;
    lexp_q <= lexp_d;
    frac_q <= frac_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign stat_o.last     = last_q;
  assign stat_o.stereo   = stereo_q;
  assign stat_o.is_float = fmt_i;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == rmsdb_pkg::OP_EMIT) |-> (!out_valid_q || !out_stall_i))
    else $error("result beat overwritten while held");

  a_log_norm_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == rmsdb_pkg::OP_LINIT) |=> (zero_q || y_q[31]))
    else $error("log operand not normalised");

  a_log_norm_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == rmsdb_pkg::OP_LUPD && !zero_q) |=> y_q[31])
    else $error("log operand lost normalisation");

endmodule

/* hw/rtl/rms_level_meter_db.sv */
// RMS level meter in dB for one buffer of interleaved int16 or float32 audio. Samples
// arrive one beat each; only the last 512 frames of a buffer count, and on the beat marked
// last_sample one result beat carries both channel levels in signed Q8.8 dB, clamped to
// -100..0 dB (right reads -100 dB in mono). An ordinary sample beat is captured, then squared
// on the shared 32x32 multiplier, then accumulated. For each channel the final beat then
// runs a 15-step restoring divider and a 24-step squaring log2 loop, the loop on the shared
// multiplier path (float first scales the sum there too), and one result beat is then loaded
// into the output register. The final beat takes longer while a held result blocks the output
// register. Sample beats are taken again as soon as the result sits in the output register.
// Write sample_format and channel_count only while idle.
module rms_level_meter_db (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [1:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rmsdb_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rmsdb_pkg::out_beat_t out_data_o
);

  logic       fmt_q, fmt_d;
  logic [1:0] chn_q, chn_d;

  rmsdb_pkg::dp_cmd_t  cmd;
  rmsdb_pkg::dp_stat_t stat;

  always_comb begin
    fmt_d = fmt_q;
    chn_d = chn_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmsdb_pkg::REG_FORMAT:   fmt_d = cfg_data_i[0];
        rmsdb_pkg::REG_CHANNELS: chn_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
      chn_q <= 2'd2;
    end else begin
      fmt_q <= fmt_d;
      chn_q <= chn_d;
    end
  end

  rmsdb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rmsdb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_i       (fmt_q),
    .chn_i       (chn_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/rms_level_meter_db_test.sv */
module rms_level_meter_db_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE      = 200;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic       FMT_INT16 = 1'b0;
  localparam logic       FMT_FLOAT = 1'b1;
  localparam logic [1:0] CH_NONE   = 2'd0;
  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;
  localparam logic [1:0] CH_THREE  = 2'd3;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_idx   = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  rmsdb_pkg::in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rmsdb_pkg::out_beat_t out_beat;

  // predicted block state
  logic [47:0] acc_sq [2];
  logic        next_ch;
  logic [15:0] frame_no;
  logic        fmt_q;
  logic [1:0]  chans_q;

  rmsdb_pkg::out_beat_t levels_due[$];

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned beats_sent    = 0;
  int unsigned buffers_int   = 0;
  int unsigned buffers_float = 0;
  int unsigned cycle_count   = 0;
  bit          calm          = 1'b0;
  int unsigned hold_ask      = 0;
  int unsigned hold_grant    = 0;
  int unsigned hold_left     = 0;

  rms_level_meter_db DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] q15_square(logic [31:0] bits, logic is_float);
    logic [16:0]  mag;
    logic [7:0]   e;
    logic [22:0]  m;
    int unsigned  sh;
    e = bits[30:23];
    m = bits[22:0];
    if (is_float == FMT_INT16) begin
      mag = bits[15] ? (17'h10000 - {1'b0, bits[15:0]}) : {1'b0, bits[15:0]};
    end else if (e == 8'hFF) begin
      mag = (m != 0) ? 17'd0 : (bits[31] ? 17'd32768 : 17'd32767);
    end else if (e == 8'h00) begin
      mag = 17'd0;
    end else if (e >= 8'd127) begin
      mag = bits[31] ? 17'd32768 : 17'd32767;
    end else begin
      sh  = 135 - int'(e);
      mag = (sh > 31) ? 17'd0 : 17'({1'b1, m} >> sh);
    end
    return 32'(mag) * 32'(mag);
  endfunction

  // log2 in Q.24 by repeated squaring, truncating
  function automatic logic [63:0] log2_fix24(logic [31:0] x);
    int unsigned n;
    int          i;
    logic [63:0] y;
    logic [63:0] r;
    n = 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    y = 64'(x) << (31 - n);
    r = 64'(n) << 24;
    for (i = 23; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] db_of_sum(logic [47:0] s, int unsigned n,
                                                   logic is_float);
    logic [63:0] sc;
    logic [63:0] idx;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [63:0] p;
    logic [15:0] mag16;
    sc = (64'(s) > (64'd1 << 42)) ? (64'd1 << 42) : 64'(s);
    if (is_float == FMT_FLOAT) begin
      idx = (sc * 64'(rmsdb_pkg::LOG_STEPS)) / (64'(n) << 30);
    end else begin
      idx = (sc * 64'(rmsdb_pkg::LOG_STEPS) * 64'd4) / (64'(n) * 64'd1000000000);
    end
    if (idx > 64'(rmsdb_pkg::LOG_STEPS)) idx = 64'(rmsdb_pkg::LOG_STEPS);
    if (idx == 0) return rmsdb_pkg::DB_FLOOR;
    a = log2_fix24(32'(idx));
    b = log2_fix24(32'(rmsdb_pkg::LOG_STEPS));
    d = (b > a) ? (b - a) : 64'd0;
    p = (d * 64'(rmsdb_pkg::LOG_K) + (64'd1 << 39)) >> 40;
    if (p > 64'd25600) p = 64'd25600;
    mag16 = p[15:0];
    return 16'sd0 - $signed(mag16);
  endfunction

  function automatic void accumulate_sample(rmsdb_pkg::in_beat_t b);
    logic        stereo;
    logic        ch;
    int unsigned start;
    int unsigned n;
    logic [48:0] t;
    rmsdb_pkg::out_beat_t r;
    stereo = (chans_q >= CH_STEREO);
    start  = (b.frames_in_buffer > rmsdb_pkg::WINDOW_FRAMES) ?
             (b.frames_in_buffer - rmsdb_pkg::WINDOW_FRAMES) : 0;
    if (!stereo) next_ch = 1'b0;
    ch = next_ch;
    if (frame_no >= start) begin
      t = 49'(acc_sq[ch]) + 49'(q15_square(b.sample_bits, fmt_q));
      acc_sq[ch] = (t > 49'(rmsdb_pkg::SUM_MAX)) ? rmsdb_pkg::SUM_MAX : t[47:0];
    end
    if (stereo && !ch) begin
      next_ch = 1'b1;
    end else begin
      next_ch  = 1'b0;
      frame_no = frame_no + 16'd1;
    end
    if (b.last_sample) begin
      n = (b.frames_in_buffer < rmsdb_pkg::WINDOW_FRAMES) ? b.frames_in_buffer :
          rmsdb_pkg::WINDOW_FRAMES;
      if (n == 0) n = 1;
      r.left_level_db  = db_of_sum(acc_sq[0], n, fmt_q);
      r.right_level_db = stereo ? db_of_sum(acc_sq[1], n, fmt_q) : rmsdb_pkg::DB_FLOOR;
      levels_due.push_back(r);
      if (fmt_q == FMT_FLOAT) buffers_float++;
      else buffers_int++;
      acc_sq[0] = '0;
      acc_sq[1] = '0;
      next_ch   = 1'b0;
      frame_no  = '0;
    end
  endfunction

  task automatic send_beat(logic [31:0] bits, logic [15:0] frames, logic last);
    rmsdb_pkg::in_beat_t b;
    b.sample_bits      = bits;
    b.frames_in_buffer = frames;
    b.last_sample      = last;
    if (!calm) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk_i); while (in_stall);
    accumulate_sample(b);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == rmsdb_pkg::REG_FORMAT) fmt_q = data[0];
    else chans_q = data;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_sample(int unsigned amp);
    int unsigned mag;
    int unsigned r;
    logic [15:0] v;
    logic [7:0]  e;
    if (fmt_q == FMT_INT16) begin
      mag = $urandom_range(0, 1 << amp);
      v   = 16'(mag);
      if ($urandom_range(1)) v = -v;
      return {16'($urandom), v};
    end
    r = $urandom_range(99);
    if (r < 5) return $urandom;
    if (r < 8) begin
      case ($urandom_range(2))
        0: e = 8'h00;
        1: e = 8'hFF;
        default: e = 8'($urandom_range(127, 254));
      endcase
    end else begin
      e = 8'(126 - $urandom_range(0, amp + 4));
    end
    return {1'($urandom_range(1)), e, 23'($urandom)};
  endfunction

  task automatic random_buffer();
    int unsigned kind;
    int unsigned frames;
    int unsigned per;
    int unsigned count;
    int unsigned amp;
    int unsigned i;
    logic [15:0] fr;
    kind = $urandom_range(99);
    if (kind < 65) frames = $urandom_range(1, 12);
    else if (kind < 75) frames = $urandom_range(13, 40);
    else if (kind < 82) frames = 0;
    else frames = $urandom_range(41, 65535);
    per = (chans_q >= CH_STEREO) ? 2 : 1;
    if (frames == 0) count = $urandom_range(1, 4);
    else if (frames > 40) count = $urandom_range(1, 12);
    else if ($urandom_range(99) < 80) count = frames * per;
    else count = $urandom_range(1, frames * per + 3);
    amp = $urandom_range(15);
    for (i = 0; i < count; i++) begin
      fr = ($urandom_range(99) < 4) ? 16'($urandom) : 16'(frames);
      send_beat(random_sample(amp), fr, i == count - 1);
    end
  endtask

  task automatic test_int16_extremes();
    send_beat(32'h0000_8000, 16'd2, 1'b0);
    send_beat(32'h0000_0000, 16'd2, 1'b0);
    send_beat(32'hFFFF_7FFF, 16'd2, 1'b0);
    send_beat(32'h1234_FFFF, 16'd2, 1'b1);
    send_beat(32'hA5A5_0400, 16'd1, 1'b0);
    send_beat(32'h5A5A_0100, 16'd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_float_specials();
    write_reg(rmsdb_pkg::REG_FORMAT, {1'b0, FMT_FLOAT});
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_STEREO);
    send_beat(32'h7FC0_0000, 16'd4, 1'b0);  // NaN
    send_beat(32'hFF80_0000, 16'd4, 1'b0);  // -inf
    send_beat(32'h7F80_0000, 16'd4, 1'b0);  // +inf
    send_beat(32'h0000_0001, 16'd4, 1'b0);  // subnormal
    send_beat(32'hBF80_0000, 16'd4, 1'b0);  // -1.0 saturates
    send_beat(32'h3F7F_FFFF, 16'd4, 1'b0);  // just under 1.0
    send_beat(32'h3380_0000, 16'd4, 1'b0);  // too small, truncates to 0
    send_beat(32'h8000_0000, 16'd4, 1'b1);  // -0
    wait_drained();
  endtask

  task automatic test_channel_modes();
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_MONO);
    send_beat(32'h3E80_0000, 16'd2, 1'b0);
    send_beat(32'hBE80_0000, 16'd2, 1'b1);
    wait_drained();
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_NONE);
    send_beat(32'h3F00_0000, 16'd1, 1'b1);
    wait_drained();
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_THREE);
    send_beat(32'h3D00_0000, 16'd1, 1'b0);
    send_beat(32'hBC00_0000, 16'd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_zero_frames();
    write_reg(rmsdb_pkg::REG_FORMAT, {1'b1, FMT_INT16});
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_STEREO);
    send_beat(32'h0000_7FFF, 16'd0, 1'b0);
    send_beat(32'h0000_8000, 16'd0, 1'b1);
    wait_drained();
  endtask

  // stereo buffer half done, then mono float from the next beat on
  task automatic test_config_mid_buffer();
    send_beat(32'h0000_1000, 16'd3, 1'b0);
    send_beat(32'h0000_F000, 16'd3, 1'b0);
    send_beat(32'h0000_0800, 16'd3, 1'b0);
    wait_drained();
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_MONO);
    write_reg(rmsdb_pkg::REG_FORMAT, {1'b0, FMT_FLOAT});
    send_beat(32'h3C80_0000, 16'd3, 1'b0);
    send_beat(32'hBD00_0000, 16'd3, 1'b1);
    wait_drained();
  endtask

  // full-scale head outside the window must not count
  task automatic test_window_tail();
    int unsigned frames;
    int unsigned i;
    write_reg(rmsdb_pkg::REG_FORMAT, {1'b0, FMT_INT16});
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_MONO);
    frames = $urandom_range(513, 530);
    for (i = 0; i < frames; i++) begin
      if (i < frames - rmsdb_pkg::WINDOW_FRAMES) begin
        send_beat(32'h0000_8000, 16'(frames), 1'b0);
      end else begin
        send_beat(random_sample(8), 16'(frames), i == frames - 1);
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    int unsigned i;
    write_reg(rmsdb_pkg::REG_CHANNELS, CH_STEREO);
    hold_ask++;
    for (i = 0; i < 6; i++) random_buffer();
    wait_drained();
  endtask

  task automatic test_random_buffers();
    int unsigned phase;
    int unsigned start_beats;
    int unsigned start_bufs;
    int unsigned r;
    int unsigned k;
    phase       = 0;
    start_beats = beats_sent;
    start_bufs  = buffers_int + buffers_float;
    while (beats_sent - start_beats < 200 || buffers_int + buffers_float - start_bufs < 20) begin
      wait_drained();
      write_reg(rmsdb_pkg::REG_FORMAT, {1'($urandom_range(1)), 1'($urandom_range(1))});
      r = $urandom_range(99);
      if (r < 45) write_reg(rmsdb_pkg::REG_CHANNELS, CH_STEREO);
      else if (r < 85) write_reg(rmsdb_pkg::REG_CHANNELS, CH_MONO);
      else if (r < 93) write_reg(rmsdb_pkg::REG_CHANNELS, CH_NONE);
      else write_reg(rmsdb_pkg::REG_CHANNELS, CH_THREE);
      calm = (phase == 3 || phase == 4);
      for (k = 0; k < 4; k++) random_buffer();
      phase++;
    end
    calm = 1'b0;
  endtask

  function automatic void flag_mismatch(string what, logic signed [15:0] want,
                                        logic signed [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s level, result %0d: expected %0d got %0d",
               what, results_seen, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (hold_grant != hold_ask) begin
      hold_grant = hold_ask;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 13);
    end
  end

  always @(posedge clk_i) begin : check_levels
    rmsdb_pkg::out_beat_t want;
    if (out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: left %0d right %0d",
                   out_beat.left_level_db, out_beat.right_level_db);
        end
      end else begin
        want = levels_due.pop_front();
        if (want.left_level_db !== out_beat.left_level_db) begin
          flag_mismatch("left", want.left_level_db, out_beat.left_level_db);
        end
        if (want.right_level_db !== out_beat.right_level_db) begin
          flag_mismatch("right", want.right_level_db, out_beat.right_level_db);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, levels_due.size());
      $display("FAIL rms_level_meter_db");
      $finish;
    end
  end

  initial begin
    acc_sq[0] = '0;
    acc_sq[1] = '0;
    next_ch   = 1'b0;
    frame_no  = '0;
    fmt_q     = FMT_INT16;
    chans_q   = CH_STEREO;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_int16_extremes();
    test_float_specials();
    test_channel_modes();
    test_zero_frames();
    test_config_mid_buffer();
    test_window_tail();
    test_backpressure();
    test_random_buffers();
    wait_drained();
    $display("run: %0d sample beats, %0d int16 and %0d float buffers, %0d levels checked",
             beats_sent, buffers_int, buffers_float, results_seen);
    $display("mono, stereo, odd channel codes, window tail and long output hold exercised");
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("PASS rms_level_meter_db");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL rms_level_meter_db");
    end
    $finish;
  end

endmodule
